[sv/dqsd_pkg.sv]
// Types and constants shared by the bounded deque with search and delete.
package dqsd_pkg;

  localparam int KEY_W  = 32;
  localparam int POS_W  = 4;
  localparam int CNT_W  = 5;
  localparam int CAP_W  = 5;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

  // Word index of the capacity register (paddr[2]).
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DELETE     = 3'd4,
    OP_SEARCH     = 3'd5,
    OP_CLEAR      = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Which cell a command picks out along the chain.
  typedef enum logic [1:0] {
    SEL_NONE  = 2'd0,
    SEL_FIRST = 2'd1,
    SEL_LAST  = 2'd2,
    SEL_MATCH = 2'd3
  } sel_e;

  typedef struct packed {
    logic [2:0]       op;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
    logic [KEY_W-1:0] removed_key;
    logic [CNT_W-1:0] count;
  } out_item_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    sel_e             sel;
    logic             add_back;
    logic             add_front;
    logic             shift_down;
    logic [KEY_W-1:0] key;
  } cell_cmd_t;

endpackage

[sv/dqsd_cell.sv]
// One storage cell of the deque chain: holds one key and forwards the first selected entry.
module dqsd_cell
  import dqsd_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX   = 0
) (
  input  logic                       clk,
  input  cell_cmd_t                  cmd,
  input  logic [$clog2(DEPTH+1)-1:0] occ,
  input  logic [KEY_W-1:0]           left_val,
  input  logic [KEY_W-1:0]           right_val,
  output logic [KEY_W-1:0]           entry,
  input  logic                       found_in,
  input  logic [$clog2(DEPTH)-1:0]   pos_in,
  input  logic [KEY_W-1:0]           key_in,
  output logic                       found_out,
  output logic [$clog2(DEPTH)-1:0]   pos_out,
  output logic [KEY_W-1:0]           key_out
);

  localparam int CW = $clog2(DEPTH+1);
  localparam int PW = $clog2(DEPTH);
  localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
  localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);

  logic [KEY_W-1:0] entry_r;
  logic [KEY_W-1:0] entry_nxt;
  logic             valid;
  logic             sel;

  assign valid = (MY_IDX < occ);

  always_comb begin
    case (cmd.sel)
      SEL_FIRST: sel = valid && (IDX == 0);
      SEL_LAST:  sel = valid && (MY_NEXT == occ);
      SEL_MATCH: sel = valid && (entry_r == cmd.key);
      default:   sel = 1'b0;
    endcase
  end

  // Pass along the first hit seen from the front.
  assign found_out = found_in | sel;
  assign pos_out   = found_in ? pos_in : PW'(IDX);
  assign key_out   = found_in ? key_in : entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.add_front) begin
      entry_nxt = left_val;
    end else if (cmd.shift_down && found_out) begin
      entry_nxt = right_val;
    end else if (cmd.add_back && (MY_IDX == occ)) begin
      entry_nxt = cmd.key;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

[sv/dqsd_ctrl.sv]
// Command decode, occupancy count and result register of the deque.
module dqsd_ctrl
  import dqsd_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  in_item_t                   in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output out_item_t                  out_data,
  input  logic [CAP_W-1:0]           capacity,
  output cell_cmd_t                  cmd,
  output logic [$clog2(DEPTH+1)-1:0] occ,
  input  logic                       hit_found,
  input  logic [$clog2(DEPTH)-1:0]   hit_pos,
  input  logic [KEY_W-1:0]           hit_key
);

  localparam int CW = $clog2(DEPTH+1);
  localparam int PW = $clog2(DEPTH);

  logic [CW-1:0] occ_r;
  logic [CW-1:0] occ_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  out_item_t     out_data_r;
  out_item_t     out_data_nxt;

  logic          in_fire;
  logic          empty;
  logic          full;
  status_e       status;
  logic [PW-1:0] pos;
  logic [KEY_W-1:0] removed;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign empty    = (occ_r == '0);
  // Capacity above DEPTH saturates; DEPTH itself always stops a push.
  assign full     = (occ_r == CW'(DEPTH)) || (32'(occ_r) >= 32'(capacity));

  always_comb begin
    cmd        = '0;
    cmd.sel    = SEL_NONE;
    cmd.key    = in_data.key;
    status     = ST_OK;
    pos        = '0;
    removed    = '0;
    occ_nxt    = occ_r;
    case (in_data.op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.add_back  = in_fire && (in_data.op == OP_PUSH_BACK);
          cmd.add_front = in_fire && (in_data.op == OP_PUSH_FRONT);
          occ_nxt       = occ_r + 1'b1;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cmd.sel        = (in_data.op == OP_POP_FRONT) ? SEL_FIRST : SEL_LAST;
          cmd.shift_down = in_fire && (in_data.op == OP_POP_FRONT);
          pos            = hit_pos;
          removed        = hit_key;
          occ_nxt        = occ_r - 1'b1;
        end
      end
      OP_DELETE, OP_SEARCH: begin
        cmd.sel = SEL_MATCH;
        if (empty) begin
          status = ST_EMPTY;
        end else if (!hit_found) begin
          status = ST_NOTFOUND;
        end else begin
          pos = hit_pos;
          if (in_data.op == OP_DELETE) begin
            cmd.shift_down = in_fire;
            removed        = hit_key;
            occ_nxt        = occ_r - 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        if (empty) begin
          status = ST_EMPTY;
        end
        occ_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_data_nxt             = out_data_r;
    out_data_nxt.status      = status;
    out_data_nxt.position    = POS_W'(pos);
    out_data_nxt.removed_key = removed;
    out_data_nxt.count       = CNT_W'(occ_nxt);
    out_valid_nxt            = in_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        occ_r <= occ_nxt;
      end
    end
  end

  // Result payload: load on every accepted beat.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign occ       = occ_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.op == OP_PUSH_BACK || in_data.op == OP_PUSH_FRONT) && !full
    |=> occ_r == $past(occ_r) + 1'b1)
    else $error("accepted push did not grow the deque");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.op == OP_CLEAR |=> occ_r == '0)
    else $error("clear left entries behind");

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r && out_data_r.count == CNT_W'(occ_r))
    else $error("reported count differs from occupancy");

endmodule

[sv/bounded_deque_search_delete.sv]
// Top level of the bounded deque with search and delete: config register and cell chain.
//
//   channel  direction  handshake                  payload
//   in_      input      in_valid / in_ready        in_item_t  {op, key}
//   out_     output     out_valid / out_ready      out_item_t {status, position,
//                                                              removed_key, count}
//   cfg_     input      APB psel/penable/pwrite    capacity at byte address 0
//
// Each command is resolved combinationally: all cells compare against the key at
// once and the chain hands the first hit toward the back in the same cycle.
// The result sits in an output register; a new beat is taken while that
// register drains, so a command per cycle flows when out_ready stays high.
// Reset clears the count, the result valid and sets capacity to 10; cell
// contents are left as they are. A stalled result holds the input off.
module bounded_deque_search_delete
  import dqsd_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int CW = $clog2(DEPTH+1);
  localparam int PW = $clog2(DEPTH);

  logic [CAP_W-1:0] cap_r;
  logic [CAP_W-1:0] cap_nxt;
  logic             cfg_wr;

  cell_cmd_t        cmd;
  logic [CW-1:0]    occ;
  logic [KEY_W-1:0] entry   [DEPTH];
  logic             found_c [DEPTH+1];
  logic [PW-1:0]    pos_c   [DEPTH+1];
  logic [KEY_W-1:0] key_c   [DEPTH+1];

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_CAPACITY) ? DATA_W'(cap_r) : '0;

  always_comb begin
    cap_nxt = cap_r;
    if (cfg_wr && (cfg_paddr[2] == REG_CAPACITY)) begin
      cap_nxt = cfg_pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  dqsd_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .capacity  (cap_r),
    .cmd       (cmd),
    .occ       (occ),
    .hit_found (found_c[DEPTH]),
    .hit_pos   (pos_c[DEPTH]),
    .hit_key   (key_c[DEPTH])
  );

  assign found_c[0] = 1'b0;
  assign pos_c[0]   = '0;
  assign key_c[0]   = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] left_val;
    logic [KEY_W-1:0] right_val;

    // Front cell takes the pushed key; back cell shifts in nothing useful.
    if (i == 0) begin : g_front
      assign left_val = cmd.key;
    end else begin : g_mid_l
      assign left_val = entry[i-1];
    end
    if (i == DEPTH-1) begin : g_back
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = entry[i+1];
    end

    dqsd_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ),
      .left_val  (left_val),
      .right_val (right_val),
      .entry     (entry[i]),
      .found_in  (found_c[i]),
      .pos_in    (pos_c[i]),
      .key_in    (key_c[i]),
      .found_out (found_c[i+1]),
      .pos_out   (pos_c[i+1]),
      .key_out   (key_c[i+1])
    );
  end

endmodule
